>>> rtl/chte_pkg.sv
// Package: shared word types and status codes for the chained hash table engine.
`timescale 1ns / 1ps
package chte_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] key;
    logic [31:0]        order_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [8:0]  entry_count;
  } rsp_t;

endpackage

>>> rtl/chained_hash_table_engine.sv
// Top level: hash table with separate chaining over a fixed entry pool.
// Steps: |key| has its upper half folded while it is 2^16 or more (one fold for 64 buckets),
// is reduced by reciprocal, the bucket head is read, and each chain entry is read and compared,
// a miss ending on the null link; a new insert adds a link step, a remove an unlink and a free
// step. Throughput: one word in flight; the next word is taken once the result is registered,
// and a result held on the output stalls only the last step of the next word.
// Reset: asynchronous, active low; a sweep then marks every bucket null.
`timescale 1ns / 1ps
module chained_hash_table_engine #(
  parameter int BUCKETS  = 64,
  parameter int CAPACITY = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  chte_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output chte_pkg::rsp_t  out_data_o
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = $clog2(CAPACITY + 1);   // holds the null marker
  localparam int AW = $clog2(CAPACITY);
  localparam logic [EW-1:0] NIL = EW'(CAPACITY);
  localparam logic [31:0] NB = 32'(BUCKETS);
  // Modulo constants: 2^16 mod BUCKETS for folding, and a reciprocal that
  // gives the exact quotient of any value below 2^16.
  localparam int SH   = 16 + $clog2(BUCKETS);
  localparam int R16  = 65536 % BUCKETS;
  localparam int MREC = ((1 << SH) + BUCKETS - 1) / BUCKETS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_RECIP, S_MULB, S_HEAD, S_HEADW, S_RD, S_CMP,
    S_ALLOC, S_LINK, S_UNLINK, S_FREE, S_DONE
  } state_e;

  // Memories: bucket heads and the entry pool.
  logic [EW-1:0] head_mem [BUCKETS];
  logic [31:0]   key_mem  [CAPACITY];
  logic [31:0]   pay_mem  [CAPACITY];
  logic [EW-1:0] link_mem [CAPACITY];

  state_e         state_q;
  chte_pkg::req_t req_q;
  logic [31:0]    rem_q;       // |key|, reduced modulo BUCKETS step by step
  logic [15:0]    quo_q;
  logic [BW-1:0]  bkt_q;
  logic [EW-1:0]  cur_q, prev_q, nxt_q;
  logic [31:0]    rkey_q, rpay_q;
  logic [EW-1:0]  free_q, fresh_q;
  logic [EW-1:0]  held_q;
  logic [EW:0]    steps_q;
  logic [EW-1:0]  hrd_q;
  logic [2:0]     stat_q;
  logic [31:0]    fval_q;
  chte_pkg::rsp_t out_q;

  // Shared unit: one multiplier folds the upper half of |key|, then forms
  // the quotient by reciprocal and multiplies it back by BUCKETS.
  logic [16:0] mul_a;
  logic [17:0] mul_b;
  logic [34:0] prod;
  always_comb begin
    if (state_q == S_MOD) begin
      mul_a = {1'b0, rem_q[31:16]};
      mul_b = 18'(R16);
    end else if (state_q == S_RECIP) begin
      mul_a = {1'b0, rem_q[15:0]};
      mul_b = 18'(MREC);
    end else begin
      mul_a = {1'b0, quo_q};
      mul_b = 18'(BUCKETS);
    end
  end
  assign prod = 35'(mul_a) * 35'(mul_b);

  // Fold the signed remainder into 0..BUCKETS-1.
  logic [31:0] fold;
  always_comb begin
    fold = rem_q;
    if (req_q.key[31] && rem_q != 32'd0) fold = NB - rem_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bkt_q       <= '0;
      free_q      <= NIL;
      fresh_q     <= '0;
      held_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != S_DONE) out_valid_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          // Sweep every bucket head to null.
          head_mem[bkt_q] <= NIL;
          bkt_q <= bkt_q + 1'b1;
          if (32'(bkt_q) == NB - 32'd1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q   <= in_data_i;
            rem_q   <= in_data_i.key[31] ? 32'(-in_data_i.key) : in_data_i.key;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          // Fold the upper half until the value fits in 16 bits.
          if (rem_q[31:16] != 16'd0) rem_q <= prod[31:0] + {16'd0, rem_q[15:0]};
          else                        state_q <= S_RECIP;
        end
        S_RECIP: begin
          quo_q   <= 16'(prod >> SH);
          state_q <= S_MULB;
        end
        S_MULB: begin
          rem_q   <= rem_q - prod[31:0];
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          bkt_q   <= BW'(fold);
          state_q <= S_HEADW;
        end
        S_HEADW: begin
          hrd_q   <= head_mem[bkt_q];
          cur_q   <= head_mem[bkt_q];
          prev_q  <= NIL;
          steps_q <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          // Read the entry at cur, or end the walk.
          if (cur_q >= NIL || steps_q >= (EW+1)'(CAPACITY)) begin
            cur_q   <= NIL;
            state_q <= S_ALLOC;
          end else begin
            rkey_q  <= key_mem[cur_q[AW-1:0]];
            rpay_q  <= pay_mem[cur_q[AW-1:0]];
            nxt_q   <= link_mem[cur_q[AW-1:0]];
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (rkey_q == req_q.key) begin
            state_q <= S_ALLOC;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= nxt_q;
            steps_q <= steps_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_ALLOC: begin
          // Decide the outcome; cur is the hit or null.
          fval_q  <= '0;
          stat_q  <= chte_pkg::ST_NOT_FOUND;
          state_q <= S_DONE;
          unique case (req_q.opcode)
            chte_pkg::OP_INSERT: begin
              if (cur_q != NIL) begin
                pay_mem[cur_q[AW-1:0]] <= req_q.order_value;
                stat_q <= chte_pkg::ST_UPDATED;
              end else if (free_q != NIL) begin
                cur_q   <= free_q;
                free_q  <= link_mem[free_q[AW-1:0]];
                state_q <= S_LINK;
              end else if (fresh_q != NIL) begin
                cur_q   <= fresh_q;
                fresh_q <= fresh_q + 1'b1;
                state_q <= S_LINK;
              end else begin
                stat_q <= chte_pkg::ST_FULL;
              end
            end
            chte_pkg::OP_SEARCH: begin
              if (cur_q != NIL) begin
                fval_q <= rpay_q;
                stat_q <= chte_pkg::ST_FOUND;
              end
            end
            chte_pkg::OP_REMOVE: begin
              if (cur_q != NIL) state_q <= S_UNLINK;
            end
            default: ;
          endcase
        end
        S_LINK: begin
          key_mem[cur_q[AW-1:0]]  <= req_q.key;
          pay_mem[cur_q[AW-1:0]]  <= req_q.order_value;
          link_mem[cur_q[AW-1:0]] <= hrd_q;
          head_mem[bkt_q]         <= cur_q;
          held_q                  <= held_q + 1'b1;
          stat_q                  <= chte_pkg::ST_INSERTED;
          state_q                 <= S_DONE;
        end
        S_UNLINK: begin
          if (prev_q != NIL) link_mem[prev_q[AW-1:0]] <= nxt_q;
          else               head_mem[bkt_q] <= nxt_q;
          if (held_q != '0) held_q <= held_q - 1'b1;
          stat_q  <= chte_pkg::ST_REMOVED;
          state_q <= S_FREE;
        end
        S_FREE: begin
          // Push the released entry onto the free list.
          link_mem[cur_q[AW-1:0]] <= free_q;
          free_q  <= cur_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the previous word has left.
          if (!out_valid_o || out_ready_i) begin
            out_q.status      <= stat_q;
            out_q.found_value <= fval_q;
            out_q.entry_count <= 9'(held_q);
            out_valid_o       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
